/* rtl/homogeneous_transform_apply_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the homogeneous transform block
// Shared property shapes, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HOMOGENEOUS_TRANSFORM_APPLY_TOP_MACROS_SVH
`define HOMOGENEOUS_TRANSFORM_APPLY_TOP_MACROS_SVH

// same-cycle implication
`define HTA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/hta_pkg.sv */
// ----------------------------------------------------------------------------
// hta_pkg
// Types and constants of the homogeneous transform block.
// ----------------------------------------------------------------------------
package hta_pkg;

  localparam int NUM_REGS  = 8;
  localparam int REG_BITS  = 64;
  localparam int IDX_BITS  = 3;
  localparam int COEF_BITS = 32;
  localparam int OUT_BITS  = 32;
  localparam int FRAC_BITS = 16;

  // register indexes
  localparam logic [IDX_BITS-1:0] REG_ROW0_COLS01 = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_ROW0_COLS23 = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_ROW1_COLS01 = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_ROW1_COLS23 = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_ROW2_COLS01 = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_ROW2_COLS23 = 3'd5;
  localparam logic [IDX_BITS-1:0] REG_ROW3_COLS01 = 3'd6;
  localparam logic [IDX_BITS-1:0] REG_ROW3_COLS23 = 3'd7;

  // identity matrix
  localparam logic [REG_BITS-1:0] RST_DIAG_LO = 64'h0000_0000_0001_0000;
  localparam logic [REG_BITS-1:0] RST_DIAG_HI = 64'h0001_0000_0000_0000;
  localparam logic [REG_BITS-1:0] RST_ZERO    = 64'h0;

  localparam logic [FRAC_BITS+1:0] ONE_Q16 = 18'h10000;

  typedef struct packed {
    logic div;   // w is neither zero nor one: take the quotient
    logic wz;    // point with zero w
  } mode_t;

endpackage

/* rtl/homogeneous_transform_apply_top.sv */
// ----------------------------------------------------------------------------
// homogeneous_transform_apply_top
// 4x4 Q16.16 matrix applied to a point or direction, with perspective divide
// and saturation.
// ----------------------------------------------------------------------------
//  channel | signals                                  | role
//  in      | in_valid, in_stall, func, in_x/y/z       | coordinate request
//  out     | out_valid, out_stall, out_x/y/z, flags   | transformed result
//  cfg     | cfg_we, cfg_index, cfg_data              | matrix register write
//
//  One request per cycle while in_stall is low. Pipeline depth is set by
//  the restoring divider, one quotient bit per stage, three lanes in parallel.
//  Stages stall individually, so bubbles close up behind a stalled output.
//  rst (synchronous) clears valid bits and loads the identity matrix.
// ----------------------------------------------------------------------------
module homogeneous_transform_apply_top #(
  parameter int COORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [hta_pkg::IDX_BITS-1:0]  cfg_index,
  input  logic [hta_pkg::REG_BITS-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic signed [31:0]            in_x,
  input  logic signed [31:0]            in_y,
  input  logic signed [31:0]            in_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_x,
  output logic signed [31:0]            out_y,
  output logic signed [31:0]            out_z,
  output logic                          w_zero,
  output logic                          overflowed
);
  import hta_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int PRW = CB + COEF_BITS;        // product
  localparam int PW  = CB + COEF_BITS + 2;    // row sum
  localparam int RW  = PW - FRAC_BITS;        // rounded row sum
  localparam int TW  = RW + CB;               // divider remainder
  localparam int NST = CB + 5;                // pipeline stages

  // ---------------- configuration ----------------
  logic [REG_BITS-1:0] regs [NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[REG_ROW0_COLS01] <= RST_DIAG_LO;
      regs[REG_ROW0_COLS23] <= RST_ZERO;
      regs[REG_ROW1_COLS01] <= RST_DIAG_HI;
      regs[REG_ROW1_COLS23] <= RST_ZERO;
      regs[REG_ROW2_COLS01] <= RST_ZERO;
      regs[REG_ROW2_COLS23] <= RST_DIAG_LO;
      regs[REG_ROW3_COLS01] <= RST_ZERO;
      regs[REG_ROW3_COLS23] <= RST_DIAG_HI;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW0_COLS01: regs[REG_ROW0_COLS01] <= cfg_data;
        REG_ROW0_COLS23: regs[REG_ROW0_COLS23] <= cfg_data;
        REG_ROW1_COLS01: regs[REG_ROW1_COLS01] <= cfg_data;
        REG_ROW1_COLS23: regs[REG_ROW1_COLS23] <= cfg_data;
        REG_ROW2_COLS01: regs[REG_ROW2_COLS01] <= cfg_data;
        REG_ROW2_COLS23: regs[REG_ROW2_COLS23] <= cfg_data;
        REG_ROW3_COLS01: regs[REG_ROW3_COLS01] <= cfg_data;
        REG_ROW3_COLS23: regs[REG_ROW3_COLS23] <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic [NST-1:0] v;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = !out_stall;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) v[i] <= v[i-1];
      end
    end
  end

  // ---------------- stage 0: input ----------------
  logic signed [CB-1:0] c0 [3];
  logic                 vec0;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      c0[0] <= in_x[CB-1:0];
      c0[1] <= in_y[CB-1:0];
      c0[2] <= in_z[CB-1:0];
      vec0  <= func;
    end
  end

  // ---------------- stage 1: products ----------------
  logic signed [PRW-1:0] prod [4][4];
  logic                  vec1;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      vec1 <= vec0;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= $signed(regs[r*2 + c/2][(c%2)*COEF_BITS +: COEF_BITS]) * c0[c];
        end
        // w column: coefficient times 1.0 or 0
        prod[r][3] <= vec0 ? '0 :
          (PRW'($signed(regs[r*2+1][COEF_BITS +: COEF_BITS])) <<< FRAC_BITS);
      end
    end
  end

  // ---------------- stage 2: rounded row sums ----------------
  logic signed [RW-1:0] rs [4];
  logic                 vec2;
  logic signed [PW-1:0] sum_c [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum_c[r] = PW'(prod[r][0]) + PW'(prod[r][1]) + PW'(prod[r][2]) + PW'(prod[r][3])
               + PW'(1 << (FRAC_BITS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      vec2 <= vec1;
      for (int r = 0; r < 4; r++) rs[r] <= sum_c[r][PW-1:FRAC_BITS];
    end
  end

  // ---------------- stage 3: divider setup ----------------
  // index 0 holds setup values, index k the values after k quotient bits
  logic [TW-1:0]        rem  [CB+1][3];
  logic [CB-1:0]        quo  [CB+1][3];
  logic                 big  [CB+1][3];
  logic                 neg  [CB+1][3];
  logic signed [RW-1:0] raw  [CB+1][3];
  logic [RW-1:0]        dm   [CB+1];
  mode_t                mode [CB+1];

  logic [RW-1:0] wmag;
  logic [RW-1:0] rmag [3];
  logic [TW-1:0] num  [3];
  mode_t         mode_c;

  always_comb begin
    wmag = rs[3][RW-1] ? RW'(-rs[3]) : RW'(rs[3]);
    mode_c.wz  = !vec2 && (rs[3] == '0);
    mode_c.div = !vec2 && (rs[3] != '0) && (rs[3] != RW'(ONE_Q16));
    for (int k = 0; k < 3; k++) begin
      rmag[k] = rs[k][RW-1] ? RW'(-rs[k]) : RW'(rs[k]);
      num[k]  = TW'({rmag[k], FRAC_BITS'(0)});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      dm[0]   <= wmag;
      mode[0] <= mode_c;
      for (int k = 0; k < 3; k++) begin
        rem[0][k] <= num[k];
        quo[0][k] <= '0;
        // quotient of 2^CB or more always saturates
        big[0][k] <= num[k] >= (TW'(wmag) << CB);
        neg[0][k] <= rs[k][RW-1] ^ rs[3][RW-1];
        raw[0][k] <= rs[k];
      end
    end
  end

  // ---------------- stages 4..CB+3: restoring divide ----------------
  for (genvar s = 1; s <= CB; s++) begin : g_div
    localparam int B = CB - s;
    logic [TW-1:0] dsh;
    logic [TW:0]   trial [3];

    always_comb begin
      dsh = TW'(dm[s-1]) << B;
      for (int k = 0; k < 3; k++) trial[k] = {1'b0, rem[s-1][k]} - {1'b0, dsh};
    end

    always_ff @(posedge clk) begin
      if (rdy[s+3]) begin
        dm[s]   <= dm[s-1];
        mode[s] <= mode[s-1];
        for (int k = 0; k < 3; k++) begin
          rem[s][k] <= trial[k][TW] ? rem[s-1][k] : trial[k][TW-1:0];
          quo[s][k] <= {quo[s-1][k][CB-2:0], !trial[k][TW]};
          big[s][k] <= big[s-1][k];
          neg[s][k] <= neg[s-1][k];
          raw[s][k] <= raw[s-1][k];
        end
      end
    end
  end

  // ---------------- last stage: select and saturate ----------------
  localparam logic signed [CB-1:0] SMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] SMIN = {1'b1, {(CB-1){1'b0}}};

  logic signed [CB-1:0] val_c [3];
  logic [2:0]           ov_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      val_c[k] = '0;
      ov_c[k]  = 1'b0;
      if (mode[CB].wz) begin
        val_c[k] = '0;
      end else if (mode[CB].div) begin
        if (big[CB][k] || (neg[CB][k] ? (quo[CB][k][CB-1] && |quo[CB][k][CB-2:0])
                                      : quo[CB][k][CB-1])) begin
          ov_c[k]  = 1'b1;
          val_c[k] = neg[CB][k] ? SMIN : SMAX;
        end else begin
          val_c[k] = neg[CB][k] ? CB'(-quo[CB][k]) : CB'(quo[CB][k]);
        end
      end else if ((&raw[CB][k][RW-1:CB-1]) || !(|raw[CB][k][RW-1:CB-1])) begin
        val_c[k] = raw[CB][k][CB-1:0];
      end else begin
        ov_c[k]  = 1'b1;
        val_c[k] = raw[CB][k][RW-1] ? SMIN : SMAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      out_x      <= OUT_BITS'(val_c[0]);
      out_y      <= OUT_BITS'(val_c[1]);
      out_z      <= OUT_BITS'(val_c[2]);
      w_zero     <= mode[CB].wz;
      overflowed <= |ov_c;
    end
  end

  // ---------------- assertions ----------------
  logic out_zero;

  assign out_zero = (out_x == '0) && (out_y == '0) && (out_z == '0);

  `include "homogeneous_transform_apply_top_macros.svh"

  `HTA_ASSERT_NOW(a_wz_zero, out_valid && w_zero, out_zero && !overflowed, "zero w not cleared")
  `HTA_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "stall without full pipe")
  `HTA_ASSERT_NEXT(a_take, in_valid && !in_stall, v[0], "accepted request lost at entry")
  `HTA_ASSERT_NOW(a_mode_excl, v[NST-1], !(mode[CB].wz && mode[CB].div), "w mode conflict")

endmodule
